>>> design/srsw_pkg.sv
package srsw_pkg;

    // Sequence space and payload width
    localparam int SEQ_SPACE    = 8;
    localparam int SEQ_W        = $clog2(SEQ_SPACE);
    localparam int PAYLOAD_BITS = 32;
    localparam int CMD_W        = 2;
    localparam int WIN_W        = 3;

    // Window size after reset
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

    // Command codes of an input item
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [PAYLOAD_BITS-1:0] payload_word;
        logic [SEQ_W-1:0]        ack_number;
        logic                    ack_check_ok;
        logic [SEQ_W-1:0]        expired_seq;
    } t_item;

    typedef struct packed {
        logic                    send_accepted;
        logic                    tx_valid;
        logic [SEQ_W-1:0]        tx_seq;
        logic [PAYLOAD_BITS-1:0] tx_payload;
        logic                    timer_start;
        logic                    timer_stop;
        logic [SEQ_W-1:0]        stop_seq;
        logic [SEQ_W-1:0]        window_base;
        logic [SEQ_W-1:0]        next_seq_out;
        logic                    window_full;
    } t_result;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLIDE,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic slide_step;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slide_start;
        logic slide_more;
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/srsw_ctrl.sv
module srsw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  srsw_pkg::t_dp_stat   i_stat,
    output srsw_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_idle
);

    srsw_pkg::t_state r_state;
    srsw_pkg::t_state n_state;

    // Hold state, return to idle on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            srsw_pkg::ST_IDLE: begin
                if (i_valid) n_state = srsw_pkg::ST_EXEC;
            end
            srsw_pkg::ST_EXEC: begin
                n_state = i_stat.slide_start ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_DONE;
            end
            srsw_pkg::ST_SLIDE: begin
                if (!i_stat.slide_more) n_state = srsw_pkg::ST_DONE;
            end
            srsw_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = srsw_pkg::ST_IDLE;
            end
            default: n_state = srsw_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        case (r_state)
            srsw_pkg::ST_IDLE: begin
                o_idle        = 1'b1;
                o_cmd.capture = i_valid;
            end
            srsw_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            srsw_pkg::ST_SLIDE: begin
                o_cmd.slide_step = i_stat.slide_more;
            end
            srsw_pkg::ST_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: o_idle = 1'b0;
        endcase
    end

endmodule

>>> design/srsw_dp.sv
module srsw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srsw_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [srsw_pkg::WIN_W-1:0]    i_cfg_data,
    input  srsw_pkg::t_ctrl_cmd           i_cmd,
    input  logic                          i_stall,
    output srsw_pkg::t_dp_stat            o_stat,
    output logic                          o_valid,
    output srsw_pkg::t_result             o_result
);

    localparam int SW = srsw_pkg::SEQ_W;
    localparam int PW = srsw_pkg::PAYLOAD_BITS;

    logic [srsw_pkg::WIN_W-1:0]   r_ws;
    logic [SW-1:0]                r_base, n_base;
    logic [SW-1:0]                r_next, n_next;
    logic [srsw_pkg::SEQ_SPACE-1:0] r_acked, n_acked;
    logic [SW-1:0]                r_k, n_k;
    logic                         r_acc, n_acc;
    logic                         r_txv, n_txv;
    logic                         r_stop, n_stop;
    logic                         r_out_valid;
    srsw_pkg::t_item              r_item;
    srsw_pkg::t_result            r_out;
    srsw_pkg::t_result            w_res;
    logic [PW-1:0]                r_mem [srsw_pkg::SEQ_SPACE];
    logic [PW-1:0]                r_rdata;
    logic                         w_mem_we;
    logic [SW-1:0]                w_wsize;
    logic [SW-1:0]                w_end;
    logic [SW-1:0]                w_n;
    logic                         w_full;
    logic                         w_in_win;
    logic                         w_ack_ok;

    // Window arithmetic, all modulo the sequence space
    assign w_wsize  = SW'(r_ws);
    assign w_end    = r_base + w_wsize;
    assign w_n      = w_wsize - SW'(1);
    assign w_full   = (w_end == r_next);
    assign w_ack_ok = (r_item.cmd == srsw_pkg::CMD_ACK) && r_item.ack_check_ok;

    always_comb begin
        if (w_end > r_base) begin
            w_in_win = (r_item.ack_number >= r_base) && (r_item.ack_number < w_end);
        end else if (w_end < r_base) begin
            w_in_win = (r_item.ack_number >= r_base) || (r_item.ack_number < w_end);
        end else begin
            w_in_win = 1'b0;
        end
    end

    // Status back to the controller
    assign o_stat.slide_start = w_ack_ok && (r_item.ack_number == r_base);
    assign o_stat.slide_more  = (r_k < w_n) && r_acked[r_base];
    assign o_stat.out_free    = !r_out_valid || !i_stall;

    // Window update for the command in flight and for each slide step
    always_comb begin
        n_base   = r_base;
        n_next   = r_next;
        n_acked  = r_acked;
        n_k      = r_k;
        n_acc    = r_acc;
        n_txv    = r_txv;
        n_stop   = r_stop;
        w_mem_we = 1'b0;
        if (i_cmd.exec) begin
            n_acc  = 1'b0;
            n_txv  = 1'b0;
            n_stop = 1'b0;
            n_k    = '0;
            case (r_item.cmd)
                srsw_pkg::CMD_SEND: begin
                    if (!w_full) begin
                        w_mem_we        = 1'b1;
                        n_acked[r_next] = 1'b0;
                        n_acc           = 1'b1;
                        n_txv           = 1'b1;
                        n_next          = r_next + SW'(1);
                    end
                end
                srsw_pkg::CMD_ACK: begin
                    if (r_item.ack_check_ok) begin
                        n_stop = 1'b1;
                        if (r_item.ack_number == r_base) begin
                            n_acked[r_base] = 1'b0;
                            n_base          = r_base + SW'(1);
                        end else if (w_in_win) begin
                            n_acked[r_item.ack_number] = 1'b1;
                        end
                    end
                end
                srsw_pkg::CMD_TIMEOUT: begin
                    n_txv = 1'b1;
                end
                default: n_txv = 1'b0;
            endcase
        end
        if (i_cmd.slide_step) begin
            n_acked[r_base] = 1'b0;
            n_base          = r_base + SW'(1);
            n_k             = r_k + SW'(1);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= srsw_pkg::WIN_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_acked     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_ws <= i_cfg_data;
            r_base  <= n_base;
            r_next  <= n_next;
            r_acked <= n_acked;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, step flags and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.load_out) r_out <= w_res;
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_txv  <= n_txv;
        r_stop <= n_stop;
    end

    // Payload store: write on an accepted send, read at the expired number
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_next] <= r_item.payload_word;
        r_rdata <= r_mem[r_item.expired_seq];
    end

    // Assemble the result from the state after the step
    always_comb begin
        w_res               = '0;
        w_res.send_accepted = r_acc;
        w_res.tx_valid      = r_txv;
        w_res.timer_start   = r_txv;
        if (r_txv) begin
            if (r_item.cmd == srsw_pkg::CMD_SEND) begin
                w_res.tx_seq     = r_next - SW'(1);
                w_res.tx_payload = r_item.payload_word;
            end else begin
                w_res.tx_seq     = r_item.expired_seq;
                w_res.tx_payload = r_rdata;
            end
        end
        w_res.timer_stop   = r_stop;
        w_res.stop_seq     = r_stop ? r_item.ack_number : '0;
        w_res.window_base  = r_base;
        w_res.next_seq_out = r_next;
        w_res.window_full  = w_full;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> design/selective_repeat_sender_window.sv
// Selective-repeat ARQ sender window.
// Input channel (i_valid, i_item, o_stall): one command per transfer: send a
// new payload, an acknowledgement with its external checksum verdict, or a
// timer expiry. Output channel (o_valid, o_result, i_stall): one result per
// command with the transmit request, timer start/stop requests and the
// window status after the command.
// Configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) writes the
// window size; write it only while the block is idle. It is ready whenever
// no command is in progress and reset is released.
// The controller steps each command through accept, execute and result load
// and takes no new command until it is back in idle; the result is registered
// in the output register. An acknowledgement of the window base adds a slide
// state with one step per buffered acknowledgement that the window slides
// over (at most window size minus 1).
// The result sits in an output register, so a stalled receiver holds it
// there while the next command is accepted and executed; that command then
// waits for the register to free up.
// Reset (synchronous, active low) empties the window, clears all acknowledge
// marks, sets the window size to 4 and drops any pending result; the input
// and configuration channels take no transfer while reset is asserted.
module selective_repeat_sender_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  srsw_pkg::t_item             i_item,
    output logic                        o_stall,
    output logic                        o_valid,
    output srsw_pkg::t_result           o_result,
    input  logic                        i_stall,
    input  logic                        i_cfg_valid,
    input  logic [srsw_pkg::WIN_W-1:0]  i_cfg_data,
    output logic                        o_cfg_ready
);

    srsw_pkg::t_ctrl_cmd w_cmd;
    srsw_pkg::t_dp_stat  w_stat;
    logic                w_idle;

    // Accept commands and configuration only when idle and out of reset
    assign o_stall     = !w_idle || !i_rst_n;
    assign o_cfg_ready = w_idle && i_rst_n;

    srsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_idle  (w_idle)
    );

    srsw_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_stall    (i_stall),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

>>> design/srsw_checker.sv
module srsw_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input srsw_pkg::t_result o_result
);

    // Reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

    // A timer starts exactly with each transmission
    a_timer_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.timer_start == o_result.tx_valid))
        else $error("timer start without transmission");

    // An accepted send transmits the number just before the new next number
    a_send_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.send_accepted |->
            o_result.tx_valid &&
            (o_result.next_seq_out == srsw_pkg::SEQ_W'(o_result.tx_seq + 1'b1)))
        else $error("send sequence mismatch");

    // Idle transmit fields read as zero
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.tx_valid |->
            (o_result.tx_seq == '0) && (o_result.tx_payload == '0))
        else $error("transmit fields set without transmission");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_result (o_result)
);
